// ===== rtl/dpr_pkg.sv =====
// shared types and constants of the distance packet receiver
package dpr_pkg;

    localparam int unsigned PACKET_BYTES = 4;
    localparam int unsigned POS_W        = 2;
    localparam int unsigned STORE_DEPTH  = PACKET_BYTES - 1;

    localparam int unsigned HDR_W  = 8;
    localparam int unsigned DIST_W = 13;
    localparam int unsigned TICK_W = 16;
    localparam int unsigned MM_W   = 16;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned IDX_W  = 2;

    // positions of the header and checksum bytes inside a packet
    localparam logic [POS_W-1:0] POS_HEADER = '0;
    localparam logic [POS_W-1:0] POS_CHECK  = POS_W'(PACKET_BYTES - 1);

    // readings at or below this many millimetres report zero
    localparam logic [MM_W-1:0] LOW_LIMIT_MM = 16'd30;

    // divide by ten: floor(x * 52429 / 2^19) is exact for every 16-bit x
    localparam logic [MM_W-1:0] DIV10_MUL   = 16'd52429;
    localparam int unsigned     DIV10_SHIFT = 19;

    localparam logic [TICK_W-1:0] STALE_MAX = '1;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_HEADER  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_MAX     = 2'd1;
    localparam logic [IDX_W-1:0] CFG_TIMEOUT = 2'd2;

    // configuration reset values
    localparam logic [HDR_W-1:0]  RST_HEADER  = 8'd255;
    localparam logic [DIST_W-1:0] RST_MAX     = 13'd450;
    localparam logic [TICK_W-1:0] RST_TIMEOUT = 16'd1000;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef struct packed {
        logic [HDR_W-1:0]  header_byte;
        logic [DIST_W-1:0] max_distance;
        logic [TICK_W-1:0] timeout_ticks;
    } t_cfg;

    // packed so that the distance sits in the lowest bits of tdata
    typedef struct packed {
        logic              checksum_error;
        logic              packet_done;
        logic              distance_good;
        logic [DIST_W-1:0] distance_cm;
    } t_result;

endpackage

// ===== rtl/dpr_cm_conv.sv =====
// millimetre to centimetre conversion with low cutoff and upper clamp
module dpr_cm_conv
    import dpr_pkg::*;
(
    input  logic [MM_W-1:0]   i_mm,
    input  logic [DIST_W-1:0] i_max,
    output logic [DIST_W-1:0] o_cm
);

    logic [2*MM_W-1:0] w_prod;
    logic [DIST_W-1:0] w_div;

    assign w_prod = i_mm * DIV10_MUL;
    assign w_div  = w_prod[DIV10_SHIFT +: DIST_W];

    always_comb begin
        if (i_mm <= LOW_LIMIT_MM) begin
            o_cm = '0;
        end else if (w_div > i_max) begin
            o_cm = i_max;
        end else begin
            o_cm = w_div;
        end
    end

endmodule

// ===== rtl/dpr_core.sv =====
// packet alignment, checksum, held distance and staleness state
module dpr_core
    import dpr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_mode,
    input  logic [7:0]       i_byte,
    input  t_cfg             i_cfg,
    output t_result          o_res
);

    logic [POS_W-1:0]  r_pos,   n_pos;
    logic [7:0]        r_bytes [STORE_DEPTH];
    logic [DIST_W-1:0] r_held,  n_held;
    logic              r_good,  n_good;
    logic [TICK_W-1:0] r_stale, n_stale;

    logic [9:0]        w_sum;
    logic              w_match;
    logic [MM_W-1:0]   w_mm;
    logic [DIST_W-1:0] w_cm;
    logic              w_store;
    logic              w_done;
    logic              w_err;

    assign w_sum   = 10'(r_bytes[0]) + 10'(r_bytes[1]) + 10'(r_bytes[2]);
    assign w_match = (w_sum[7:0] == i_byte);
    assign w_mm    = {r_bytes[1], r_bytes[2]};

    dpr_cm_conv u_conv (
        .i_mm  (w_mm),
        .i_max (i_cfg.max_distance),
        .o_cm  (w_cm)
    );

    always_comb begin
        n_pos   = r_pos;
        n_held  = r_held;
        n_good  = r_good;
        n_stale = r_stale;
        w_store = 1'b0;
        w_done  = 1'b0;
        w_err   = 1'b0;
        if (i_mode == MODE_BYTE) begin
            if (r_pos == POS_HEADER && i_byte != i_cfg.header_byte) begin
                n_pos = POS_HEADER;
            end else if (r_pos != POS_CHECK) begin
                w_store = 1'b1;
                n_pos   = r_pos + 1'b1;
            end else begin
                w_done = 1'b1;
                n_pos  = POS_HEADER;
                if (w_match) begin
                    n_held  = w_cm;
                    n_good  = 1'b1;
                    n_stale = '0;
                end else begin
                    n_good = 1'b0;
                    w_err  = 1'b1;
                end
            end
        end else if (r_stale != STALE_MAX) begin
            n_stale = r_stale + 1'b1;
        end
        if (n_stale >= i_cfg.timeout_ticks) begin
            n_good = 1'b0;
        end
    end

    assign o_res.distance_cm    = n_held;
    assign o_res.distance_good  = n_good;
    assign o_res.packet_done    = w_done;
    assign o_res.checksum_error = w_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_HEADER;
            r_held  <= '0;
            r_good  <= 1'b0;
            r_stale <= '0;
        end else if (i_step) begin
            r_pos   <= n_pos;
            r_held  <= n_held;
            r_good  <= n_good;
            r_stale <= n_stale;
        end
    end

    // packet byte store, always written before it is read
    always_ff @(posedge i_clk) begin
        if (i_step && w_store) begin
            r_bytes[r_pos] <= i_byte;
        end
    end

endmodule

// ===== rtl/distance_packet_receiver.sv =====
// top level of the distance packet receiver
//
// input stream: one transaction per received serial byte (tuser = 0, byte in
// tdata[7:0]) or per one-millisecond tick (tuser = 1, tdata ignored)
// output stream: exactly one transaction per input transaction, in order,
// carrying the held distance, its good mark and the packet status flags
// bytes are gathered into four-byte packets aligned on header_byte; the
// fourth byte is checked against the low byte of the sum of the first three
// path: a transaction is held in the input register, then goes through the
// state update into the result register, which drives output tvalid
// throughput: one transaction per cycle while the output is taken; the state
// update is combinational, the divide by ten one 16x16 multiply by a reciprocal
// stall: when the output is not taken the result register holds, the input
// register fills and s_axis_tready drops; nothing is lost or repeated
// reset: synchronous, active low; clears both stages, the packet position,
// held distance, good mark and stale counter, and loads the register
// defaults header 255, max distance 450 cm, timeout 1000 ticks
// configuration: i_cfg_we, i_cfg_idx; user must write only while idle; unchecked
module distance_packet_receiver
    import dpr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,

    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // rx_byte[7:0]
    input  logic             s_axis_tuser,   // mode[0]

    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // distance_cm[12:0], distance_good[13],
                                             // packet_done[14], checksum_error[15]

    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    // configuration registers
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_byte   <= RST_HEADER;
            r_cfg.max_distance  <= RST_MAX;
            r_cfg.timeout_ticks <= RST_TIMEOUT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HEADER:  r_cfg.header_byte   <= i_cfg_data[HDR_W-1:0];
                CFG_MAX:     r_cfg.max_distance  <= i_cfg_data[DIST_W-1:0];
                CFG_TIMEOUT: r_cfg.timeout_ticks <= i_cfg_data[TICK_W-1:0];
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // input register
    logic       r_in_valid;
    logic       r_in_mode;
    logic [7:0] r_in_byte;

    // result register
    logic       r_out_valid;
    t_result    r_out;

    t_result    w_res;
    logic       w_advance;

    // item moves into the result register when that register is free or drains
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_mode <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
        end
    end

    dpr_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_advance),
        .i_mode  (r_in_mode),
        .i_byte  (r_in_byte),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

endmodule

// ===== rtl/dpr_checker.sv =====
// port-level checks of the distance packet receiver and their binding
module dpr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // a stalled result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a checksum error only comes with a completed packet
    a_err_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[15] |-> m_axis_tdata[14])
        else $error("checksum error without packet done");

    // a failed packet never reports a good distance
    a_err_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[15] |-> !m_axis_tdata[13])
        else $error("good mark set on checksum error");

    // reset empties the result stage
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind distance_packet_receiver dpr_checker u_dpr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/distance_packet_receiver_tb.sv =====
`timescale 1ns / 1ps
// testbench of the distance packet receiver: byte and tick streams checked against a predictor
module distance_packet_receiver_tb;
    import dpr_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 600_000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned ZERO_BELOW_MM = 30;
    localparam int unsigned MM_PER_CM     = 10;

    // one input transaction: a serial byte or a millisecond tick
    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } t_serial_event;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata  = '0;    // rx_byte[7:0]
    logic             s_axis_tuser  = 1'b0;  // mode[0]
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [15:0]      m_axis_tdata;          // distance_cm[12:0], distance_good[13],
                                             // packet_done[14], checksum_error[15]
    logic             i_cfg_we      = 1'b0;
    logic [IDX_W-1:0] i_cfg_idx     = '0;
    logic [CFG_W-1:0] i_cfg_data    = '0;

    // events waiting for the driver, readings waiting for the output port
    t_serial_event pending_events[$];
    t_result       expected_readings[$];

    int unsigned queued_events   = 0;
    int unsigned accepted_events = 0;
    int unsigned cycle_count     = 0;
    int unsigned mismatch_count  = 0;
    int unsigned send_idle_pct   = 0;
    int unsigned stall_pct       = 0;
    bit          in_fire         = 1'b0;

    // predicted receiver state and its own copy of the registers
    logic [POS_W-1:0]  rx_slot    = POS_HEADER;
    logic [7:0]        pkt_buf [STORE_DEPTH];
    logic [DIST_W-1:0] held_cm    = '0;
    logic              fresh      = 1'b0;
    logic [TICK_W-1:0] idle_ticks = '0;
    t_cfg              cfg_shadow = '{header_byte: RST_HEADER, max_distance: RST_MAX,
                                      timeout_ticks: RST_TIMEOUT};

    distance_packet_receiver DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // advance the predicted state by one accepted transaction
    task automatic predict_reading(input t_serial_event ev, output t_result r);
        int unsigned sum;
        int unsigned mm;
        int unsigned cm;
        r = '0;
        if (ev.mode == MODE_BYTE) begin
            if (rx_slot == POS_HEADER && ev.rx_byte != cfg_shadow.header_byte) begin
                // misaligned byte: dropped, still hunting for a header
                rx_slot = POS_HEADER;
            end else if (rx_slot != POS_CHECK) begin
                pkt_buf[rx_slot] = ev.rx_byte;
                rx_slot = rx_slot + 1'b1;
            end else begin
                r.packet_done = 1'b1;
                sum = (32'(pkt_buf[0]) + 32'(pkt_buf[1]) + 32'(pkt_buf[2])) & 32'hFF;
                if (sum == 32'(ev.rx_byte)) begin
                    mm = 32'({pkt_buf[1], pkt_buf[2]});
                    // short readings report zero, everything is clamped to the max
                    cm = (mm > ZERO_BELOW_MM) ? mm / MM_PER_CM : 0;
                    if (cm > cfg_shadow.max_distance)
                        cm = cfg_shadow.max_distance;
                    held_cm    = DIST_W'(cm);
                    fresh      = 1'b1;
                    idle_ticks = '0;
                end else begin
                    // bad checksum keeps the old distance but drops the good mark
                    fresh            = 1'b0;
                    r.checksum_error = 1'b1;
                end
                rx_slot = POS_HEADER;
            end
        end else if (idle_ticks != STALE_MAX) begin
            // tick: byte ignored, counter saturates
            idle_ticks = idle_ticks + 1'b1;
        end
        // staleness is checked after every transaction of either kind
        if (idle_ticks >= cfg_shadow.timeout_ticks)
            fresh = 1'b0;
        r.distance_cm   = held_cm;
        r.distance_good = fresh;
    endtask

    // input side: present queued events, idle at random between them
    always @(negedge i_clk) begin : drive_ports
        t_serial_event ev;
        if (!s_axis_tvalid || in_fire) begin
            if (i_rst_n && pending_events.size() != 0 &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                ev = pending_events.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= ev.mode;
                s_axis_tdata  <= ev.rx_byte;
            end else begin
                // idle cycle: junk on the data lines
                s_axis_tvalid <= 1'b0;
                s_axis_tuser  <= 1'($urandom);
                s_axis_tdata  <= 8'($urandom);
            end
        end
        // output side: random back-pressure
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // sample both handshakes at the rising edge
    always @(posedge i_clk) begin : watch_ports
        t_result got;
        t_result want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            in_fire = i_rst_n && s_axis_tvalid && s_axis_tready;
            // check the output before queueing the new prediction
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata);
                if (expected_readings.size() == 0) begin
                    $error("unexpected output transaction, tdata %h", m_axis_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_readings.pop_front();
                    if (got.distance_cm != want.distance_cm) begin
                        $error("distance_cm: expected %0d, actual %0d",
                               want.distance_cm, got.distance_cm);
                        mismatch_count++;
                    end
                    if (got.distance_good != want.distance_good) begin
                        $error("distance_good: expected %0d, actual %0d",
                               want.distance_good, got.distance_good);
                        mismatch_count++;
                    end
                    if (got.packet_done != want.packet_done) begin
                        $error("packet_done: expected %0d, actual %0d",
                               want.packet_done, got.packet_done);
                        mismatch_count++;
                    end
                    if (got.checksum_error != want.checksum_error) begin
                        $error("checksum_error: expected %0d, actual %0d",
                               want.checksum_error, got.checksum_error);
                        mismatch_count++;
                    end
                end
            end
            if (in_fire) begin
                predict_reading(t_serial_event'({s_axis_tuser, s_axis_tdata}), want);
                expected_readings.push_back(want);
                accepted_events++;
            end
        end
    end

    task automatic push_event(input logic mode, input logic [7:0] rx_byte);
        pending_events.push_back('{mode: mode, rx_byte: rx_byte});
        queued_events++;
    endtask

    // header, distance high, distance low, checksum; ticks may fall in between
    task automatic queue_packet(input logic [15:0] mm, input bit corrupt,
                                input int unsigned tick_pct);
        logic [7:0] pkt [4];
        pkt[0] = cfg_shadow.header_byte;
        pkt[1] = mm[15:8];
        pkt[2] = mm[7:0];
        pkt[3] = pkt[0] + pkt[1] + pkt[2];
        if (corrupt)
            pkt[3] = pkt[3] ^ 8'($urandom_range(1, 255));
        for (int i = 0; i < 4; i++) begin
            if (i > 0 && $urandom_range(0, 99) < tick_pct)
                push_event(MODE_TICK, 8'($urandom));
            push_event(MODE_BYTE, pkt[i]);
        end
    endtask

    // millimetres: anything, near the zero threshold, near the clamp, or typical
    function automatic logic [15:0] pick_distance();
        int unsigned centre;
        int unsigned lo;
        int unsigned hi;
        centre = cfg_shadow.max_distance * MM_PER_CM;
        lo     = (centre > 20) ? centre - 20 : 0;
        hi     = (centre + 20 > 65535) ? 65535 : centre + 20;
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 45));
            2: return 16'($urandom_range(lo, hi));
            default: return 16'($urandom_range(0, 4700));
        endcase
    endfunction

    // mostly whole packets, some corrupt, plus tick bursts, noise and cut-off packets
    task automatic queue_random_traffic(input int unsigned count);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = queued_events + count;
        while (queued_events < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                queue_packet(pick_distance(), $urandom_range(0, 99) < 15, 8);
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 6)) push_event(MODE_TICK, 8'($urandom));
            end else if (pick < 95) begin
                push_event(MODE_BYTE, 8'($urandom));
            end else begin
                // header and part of a body; whatever follows completes it
                push_event(MODE_BYTE, cfg_shadow.header_byte);
                repeat ($urandom_range(0, 2)) push_event(MODE_BYTE, 8'($urandom));
            end
        end
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic load_settings(input logic [HDR_W-1:0] hdr, input logic [DIST_W-1:0] max_cm,
                                 input logic [TICK_W-1:0] timeout);
        write_reg(CFG_HEADER, CFG_W'(hdr));
        write_reg(CFG_MAX, CFG_W'(max_cm));
        write_reg(CFG_TIMEOUT, CFG_W'(timeout));
        cfg_shadow = '{header_byte: hdr, max_distance: max_cm, timeout_ticks: timeout};
    endtask

    // every event accepted and every reading out, then let the pipeline settle
    task automatic wait_until_drained();
        do
            @(negedge i_clk);
        while (accepted_events != queued_events || expected_readings.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin : run_test
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 25;
        stall_pct     = 58;

        // directed: short timeout so ticks go stale quickly
        load_settings(8'h59, 13'd6553, 16'd3);
        push_event(MODE_TICK, 8'hFF);                 // tick ignores its byte
        push_event(MODE_BYTE, 8'h00);                 // misaligned bytes are dropped
        push_event(MODE_BYTE, 8'hFF);
        queue_packet(16'hFFFF, 1'b0, 0);              // largest reading, hits the clamp
        repeat (3) push_event(MODE_TICK, 8'h00);      // third tick reaches the timeout
        queue_packet(16'd30, 1'b0, 0);                // at the threshold: zero
        queue_packet(16'd31, 1'b0, 0);                // just above it
        queue_packet(16'd1234, 1'b1, 0);              // checksum failure keeps distance
        queue_packet(16'h5959, 1'b0, 0);              // header value inside the body
        wait_until_drained();

        load_settings(8'h3C, 13'd6553, 16'd4);
        queue_random_traffic(350);
        wait_until_drained();

        // all distances clamp to zero, every tick goes stale
        load_settings(8'h00, 13'd0, 16'd1);
        queue_random_traffic(300);
        wait_until_drained();

        send_idle_pct = 58;
        stall_pct     = 25;

        load_settings(RST_HEADER, RST_MAX, RST_TIMEOUT);
        queue_random_traffic(350);
        wait_until_drained();

        load_settings(8'hC3, 13'd200, 16'd7);
        queue_random_traffic(350);
        wait_until_drained();

        send_idle_pct = 0;
        stall_pct     = 0;

        load_settings(8'($urandom), 13'($urandom_range(0, 6553)),
                      16'($urandom_range(1, 20)));
        queue_random_traffic(400);
        wait_until_drained();

        // longest timeout: a tick burst leaves the reading good
        load_settings(8'h80, 13'd6553, 16'hFFFF);
        queue_packet(16'd4321, 1'b0, 0);
        repeat (40) push_event(MODE_TICK, 8'($urandom));
        queue_packet(16'hFFFF, 1'b0, 0);
        push_event(MODE_TICK, 8'h00);
        wait_until_drained();

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/dpr_pkg.sv
rtl/dpr_cm_conv.sv
rtl/dpr_core.sv
rtl/distance_packet_receiver.sv
rtl/dpr_checker.sv
tb/distance_packet_receiver_tb.sv
